// ===== src/dip_remote_pulse_decoder_top_defines.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef DIP_REMOTE_PULSE_DECODER_TOP_DEFINES_SVH
`define DIP_REMOTE_PULSE_DECODER_TOP_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define DIP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("dip assertion failed");

// Checks that a condition implies a consequence on the same edge.
`define DIP_ASSERT_IMPL(name, clk, rst_n, cond, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
    else $error("dip implication failed");

// Checks that a condition implies a consequence on the following edge.
`define DIP_ASSERT_NEXT(name, clk, rst_n, cond, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
    else $error("dip next-cycle check failed");

`endif

// ===== src/dip_pkg.sv =====
// ----------------------------------------------------------------------------
// dip_pkg
// Shared types and constants of the pulse-width remote code decoder.
// ----------------------------------------------------------------------------
package dip_pkg;

  localparam int unsigned FrameBits = 44;  // eleven nibbles cover every pattern
  localparam int unsigned DurW      = 24;
  localparam int unsigned NomW      = 25;  // 39 * 65535 and 20 * 65535 fit here

  localparam logic [3:0] NibStop = 4'b0001;
  localparam logic [3:0] NibOne  = 4'b0011;
  localparam logic [3:0] NibZero = 4'b0111;

  localparam logic [FrameBits-1:0] Pat7Mask = 44'hF000000FF0F;
  localparam logic [FrameBits-1:0] Pat8Mask = 44'h0F00000F00F;
  localparam logic [FrameBits-1:0] Pat9Mask = 44'hF000000000F;
  localparam logic [FrameBits-1:0] Pat7Want = 44'h10000001101;
  localparam logic [FrameBits-1:0] Pat8Want = 44'h01000001001;
  localparam logic [FrameBits-1:0] Pat9Want = 44'h10000000001;

  localparam logic [3:0] MinNibbles = 4'd10;
  localparam logic [3:0] MaxNibbles = 4'd11;

  localparam logic [7:0] RegUnitTime  = 8'd0;
  localparam logic [7:0] RegTolerance = 8'd1;

  localparam logic [15:0] UnitReset = 16'd1000;
  localparam logic [15:0] TolReset  = 16'd200;

  localparam logic [1:0] LenCode7 = 2'd0;
  localparam logic [1:0] LenCode8 = 2'd1;
  localparam logic [1:0] LenCode9 = 2'd2;

  // A completed frame handed from the front end to the decode stage.
  typedef struct packed {
    logic [FrameBits-1:0] symbols;
  } frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_req_t;

endpackage

// ===== src/dip_front.sv =====
// ----------------------------------------------------------------------------
// dip_front
// Holds the timing registers, classifies each pulse and assembles frames.
// ----------------------------------------------------------------------------
module dip_front import dip_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [7:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             accept_i,
  input  logic             level_i,
  input  logic [DurW-1:0]  duration_us_i,
  output frame_req_t       frame_o
);

  typedef enum logic [1:0] {
    PhIdle,
    PhStart,
    PhLow,
    PhHigh
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [15:0]          unit_q, tol_q;
  logic [FrameBits-1:0] shift_q, shift_d;
  logic [3:0]           count_q, count_d;
  logic [DurW-1:0]      low_q, low_d;  // low half of the current pair

  logic [NomW-1:0] dur, low, u1, u2, u3, u5, u39, tol, tol20;
  logic            push_nib;
  logic [3:0]      nib;
  logic            frame_end;

  function automatic logic near(input logic [NomW-1:0] d, input logic [NomW-1:0] nom,
                                input logic [NomW-1:0] lim);
    logic [NomW-1:0] diff;
    diff = (d >= nom) ? (d - nom) : (nom - d);
    return diff < lim;
  endfunction

  // Nominal lengths are shift-and-add multiples of the unit.
  assign dur   = NomW'(duration_us_i);
  assign low   = NomW'(low_q);
  assign u1    = NomW'(unit_q);
  assign u2    = u1 << 1;
  assign u3    = u1 + u2;
  assign u5    = (u1 << 2) + u1;
  assign u39   = (u1 << 5) + (u1 << 3) - u1;
  assign tol   = NomW'(tol_q);
  assign tol20 = (tol << 4) + (tol << 2);

  always_comb begin
    phase_d   = phase_q;
    shift_d   = shift_q;
    count_d   = count_q;
    low_d     = low_q;
    push_nib  = 1'b0;
    nib       = NibStop;
    frame_end = 1'b0;
    if (accept_i) begin
      unique case (phase_q)
        PhIdle: begin
          if (!level_i && near(dur, u39, tol20)) phase_d = PhStart;
        end
        PhStart: begin
          if (level_i && near(dur, u1, tol)) begin
            shift_d = '0;
            count_d = '0;
            push_nib = 1'b1;
            phase_d  = PhLow;
          end else begin
            phase_d = PhIdle;
          end
        end
        PhLow: begin
          if (level_i) begin
            phase_d = PhIdle;
          end else if (dur > u5) begin
            frame_end = 1'b1;
            phase_d   = PhIdle;
          end else begin
            low_d   = duration_us_i;
            phase_d = PhHigh;
          end
        end
        PhHigh: begin
          phase_d = PhIdle;
          if (level_i) begin
            if (near(low, u3, tol) && near(dur, u1, tol)) begin
              push_nib = 1'b1;
              nib      = NibStop;
              phase_d  = PhLow;
            end else if (near(low, u2, tol) && near(dur, u2, tol)) begin
              push_nib = 1'b1;
              nib      = NibOne;
              phase_d  = PhLow;
            end else if (near(low, u1, tol) && near(dur, u3, tol)) begin
              push_nib = 1'b1;
              nib      = NibZero;
              phase_d  = PhLow;
            end
          end
        end
        default: phase_d = PhIdle;
      endcase
    end
    if (push_nib) begin
      shift_d = {shift_d[FrameBits-5:0], nib};
      if (count_d != 4'hF) count_d = count_d + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      unit_q  <= UnitReset;
      tol_q   <= TolReset;
      shift_q <= '0;
      count_q <= '0;
      low_q   <= '0;
    end else begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      count_q <= count_d;
      low_q   <= low_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegUnitTime:  unit_q <= cfg_data_i;
          RegTolerance: tol_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Frames of the wrong length never reach the decode stage.
  assign frame_o.valid = frame_end && (count_q >= MinNibbles) && (count_q <= MaxNibbles);
  assign frame_o.frame.symbols = shift_q;

endmodule

// ===== src/dip_frame_q.sv =====
// ----------------------------------------------------------------------------
// dip_frame_q
// Two-entry queue of completed frames between front end and decode stage.
// ----------------------------------------------------------------------------
module dip_frame_q import dip_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  frame_req_t wr_i,
  input  logic       rd_i,
  output frame_t     rd_frame_o,
  output logic       rd_valid_o,
  output logic       full_o
);

  frame_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_wr, do_rd;

  assign do_wr = wr_i.valid && !full_o;
  assign do_rd = rd_i && rd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= ~wr_ptr_q;
      if (do_rd) rd_ptr_q <= ~rd_ptr_q;
      case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_i.frame;
  end

  assign rd_frame_o = mem_q[rd_ptr_q];
  assign rd_valid_o = (count_q != 2'd0);
  assign full_o     = (count_q == 2'd2);

endmodule

// ===== src/dip_back.sv =====
// ----------------------------------------------------------------------------
// dip_back
// Matches a frame against the framing patterns and decodes the code bits.
// ----------------------------------------------------------------------------
module dip_back import dip_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  frame_t     frame_i,
  input  logic       frame_valid_i,
  output logic       frame_take_o,
  input  logic       pop,
  output logic       empty,
  output logic [8:0] code_value_o,
  output logic [1:0] code_length_o
);

  logic       out_valid_q, out_valid_d;
  logic [8:0] value_q;
  logic [1:0] length_q;
  logic [3:0] sel [9];
  logic [8:0] bits;
  logic [1:0] len;
  logic       ok;

  // Picks the payload nibble behind each code bit; unused positions read as zero.
  always_comb begin
    logic [FrameBits-1:0] d;
    d   = frame_i.symbols;
    ok  = 1'b1;
    len = LenCode9;
    for (int i = 0; i < 9; i++) sel[i] = NibZero;
    if ((d & Pat7Mask) == Pat7Want) begin
      len    = LenCode7;
      sel[0] = d[7:4];
      for (int i = 1; i < 7; i++) sel[i] = d[4*(i+3) +: 4];
    end else if ((d & Pat8Mask) == Pat8Want) begin
      len = LenCode8;
      sel[0] = d[7:4];
      sel[1] = d[11:8];
      for (int i = 3; i < 8; i++) sel[i] = d[4*(i+1) +: 4];
    end else if ((d & Pat9Mask) == Pat9Want) begin
      len = LenCode9;
      for (int i = 0; i < 9; i++) sel[i] = d[4*(i+1) +: 4];
    end else begin
      ok = 1'b0;
    end
    for (int i = 0; i < 9; i++) begin
      bits[i] = (sel[i] == NibOne);
      if (sel[i] != NibOne && sel[i] != NibZero) ok = 1'b0;
    end
  end

  assign frame_take_o = frame_valid_i && (!out_valid_q || pop);

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) out_valid_d = 1'b0;
    if (frame_take_o && ok) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_take_o && ok) begin
      value_q  <= bits;
      length_q <= len;
    end
  end

  assign empty         = !out_valid_q;
  assign code_value_o  = value_q;
  assign code_length_o = length_q;

endmodule

// ===== src/dip_remote_pulse_decoder_top.sv =====
// ----------------------------------------------------------------------------
// dip_remote_pulse_decoder_top
// Pulse-width decoder for DIP-switch remote frames.
//
// Channel   Direction  Handshake                  Payload
// pulse     in         push / full                level_i, duration_us_i
// code      out        empty / pop                code_value_o, code_length_o
// config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One pulse is taken per cycle while full is low; the front end classifies it in that cycle.
// A finished frame waits in a two-entry queue and is decoded from there
// into the output register once that register is free or being popped.
// full is high only while the frame queue holds two undecoded frames.
// Reset returns the registers to their default timing and the decoder to
// waiting for a header; configuration writes are always ready.
// ----------------------------------------------------------------------------
`include "dip_remote_pulse_decoder_top_defines.svh"

module dip_remote_pulse_decoder_top import dip_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        level_i,
  input  logic [23:0] duration_us_i,
  output logic        empty,
  input  logic        pop,
  output logic [8:0]  code_value_o,
  output logic [1:0]  code_length_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  frame_req_t front_frame;
  frame_t     q_frame;
  logic       q_valid, q_take, accept;

  assign accept      = push && !full;
  assign cfg_ready_o = 1'b1;

  dip_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .level_i       (level_i),
    .duration_us_i (duration_us_i),
    .frame_o       (front_frame)
  );

  dip_frame_q u_frame_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (front_frame),
    .rd_i       (q_take),
    .rd_frame_o (q_frame),
    .rd_valid_o (q_valid),
    .full_o     (full)
  );

  dip_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_i       (q_frame),
    .frame_valid_i (q_valid),
    .frame_take_o  (q_take),
    .pop           (pop),
    .empty         (empty),
    .code_value_o  (code_value_o),
    .code_length_o (code_length_o)
  );

  // A frame is only produced by an accepted pulse, so it always finds room.
  `DIP_ASSERT_IMPL(a_frame_has_room, clk_i, rst_ni, front_frame.valid, !full)
  // A waiting code that is not taken stays unchanged.
  `DIP_ASSERT_NEXT(a_code_held, clk_i, rst_ni, !empty && !pop,
                   !empty && $stable(code_value_o) && $stable(code_length_o))
  // The decode stage never takes a frame from an empty queue.
  `DIP_ASSERT_IMPL(a_take_valid, clk_i, rst_ni, q_take, q_valid)
  // Only the three defined length codes are ever presented.
  `DIP_ASSERT(a_len_range, clk_i, rst_ni, empty || code_length_o != 2'd3)

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse-width remote code decoder. Builds pulse
// trains of well-formed 7, 8 and 9 switch frames plus broken and noisy ones,
// predicts each decoded code and checks every popped code in order, across
// several timing settings and idle/stall mixes on both queue sides.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dip_pkg::*;

  localparam int CycleLimit   = 600000;
  localparam int SettleCycles = 8;
  localparam int MaxReports   = 10;
  localparam int RandomItems  = 900;
  localparam int DirRows      = 13;

  localparam logic [23:0] MaxDur = 24'hFFFFFF;

  localparam logic [3:0] NibbleStop = 4'h1;
  localparam logic [3:0] NibbleOne  = 4'h3;
  localparam logic [3:0] NibbleZero = 4'h7;

  localparam logic [63:0] Frame7Mask = 64'hF000000FF0F;
  localparam logic [63:0] Frame8Mask = 64'h0F00000F00F;
  localparam logic [63:0] Frame9Mask = 64'hF000000000F;
  localparam logic [63:0] Frame7Want = 64'h10000001101;
  localparam logic [63:0] Frame8Want = 64'h01000001001;
  localparam logic [63:0] Frame9Want = 64'h10000000001;

  localparam int unsigned HeaderUnits    = 39;
  localparam int unsigned HeaderTolScale = 20;
  localparam int unsigned GapUnits       = 5;
  localparam logic [3:0]  MinFrameNibbles = 4'd10;
  localparam logic [3:0]  MaxFrameNibbles = 4'd11;

  typedef enum logic [1:0] {PhIdle, PhStart, PhLow, PhHigh} phase_e;
  typedef enum logic [1:0] {SymStop, SymOne, SymZero} sym_e;
  typedef enum logic [3:0] {
    KindGood7, KindGood8, KindGood9, KindShort, KindLong, KindBadNibble,
    KindWrongLevel, KindUnmatched, KindEdge, KindNoise, KindExtremes
  } frame_kind_e;

  typedef struct packed {
    logic [8:0] value;
    logic [1:0] length;
  } code_t;

  typedef struct packed {
    logic        lvl;
    logic [23:0] dur;
  } pulse_t;

  typedef struct packed {
    frame_kind_e kind;
    logic [8:0]  bits;
    logic        typed;
    logic [8:0]  exp_value;
    logic [1:0]  exp_length;
  } dir_row_t;

  // Rows with a typed code are all-ones and all-zeros frames; the 8-switch
  // all-ones frame shows its filler position as a zero bit.
  dir_row_t dir_table [DirRows] = '{
    '{KindGood9,      9'h1FF, 1'b1, 9'h1FF, LenCode9},
    '{KindGood9,      9'h000, 1'b1, 9'h000, LenCode9},
    '{KindGood7,      9'h07F, 1'b1, 9'h07F, LenCode7},
    '{KindGood7,      9'h000, 1'b1, 9'h000, LenCode7},
    '{KindGood8,      9'h0FF, 1'b1, 9'h0FB, LenCode8},
    '{KindGood8,      9'h0A5, 1'b0, '0, '0},
    '{KindGood9,      9'h12D, 1'b0, '0, '0},
    '{KindShort,      9'h155, 1'b0, '0, '0},
    '{KindLong,       9'h0AA, 1'b0, '0, '0},
    '{KindBadNibble,  9'h1C3, 1'b0, '0, '0},
    '{KindWrongLevel, 9'h0F0, 1'b0, '0, '0},
    '{KindUnmatched,  9'h033, 1'b0, '0, '0},
    '{KindExtremes,   9'h000, 1'b0, '0, '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        level_i = 1'b0;
  logic [23:0] duration_us_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [8:0]  code_value_o;
  logic [1:0]  code_length_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  dip_remote_pulse_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .level_i       (level_i),
    .duration_us_i (duration_us_i),
    .empty         (empty),
    .pop           (pop),
    .code_value_o  (code_value_o),
    .code_length_o (code_length_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decoder copy: timing registers and frame state.
  logic [15:0] cfg_unit = UnitReset;
  logic [15:0] cfg_tol  = TolReset;
  phase_e      dec_phase = PhIdle;
  logic [63:0] dec_shift = '0;
  logic [3:0]  dec_count = '0;
  logic [23:0] dec_low   = '0;

  code_t  pending_codes [$];
  pulse_t pulse_q [$];
  logic   typed_on = 1'b0;
  code_t  typed_code = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;
  int mismatch_count = 0;
  int codes_popped   = 0;
  int pulses_sent    = 0;
  int settings_used  = 1;

  function automatic logic close_to(input logic [63:0] d, input logic [63:0] nominal,
                                    input logic [63:0] tol);
    return ((d > nominal) ? (d - nominal) : (nominal - d)) < tol;
  endfunction

  function automatic logic near_unit(input logic [63:0] d, input int unsigned units);
    return close_to(d, 64'(cfg_unit) * units, 64'(cfg_tol));
  endfunction

  function automatic logic unpack_frame(input logic [63:0] sh, input logic [3:0] cnt,
                                        output code_t res);
    logic [63:0] d;
    logic [8:0]  v;
    int          nbits;
    int          i;
    res = '0;
    v   = '0;
    if (cnt > MaxFrameNibbles) return 1'b0;
    if ((sh & Frame7Mask) == Frame7Want) begin
      d = sh & ~Frame7Mask;
      // The first payload nibble sits below the two trailing stop nibbles.
      d = (d >> 12) | ((d >> 4) & 64'hF);
      nbits = 7;
      res.length = LenCode7;
    end else if ((sh & Frame8Mask) == Frame8Want) begin
      d = (sh & ~Frame8Mask) >> 4;
      d[11:8] = d[11:8] | NibbleZero;
      nbits = 8;
      res.length = LenCode8;
    end else if ((sh & Frame9Mask) == Frame9Want) begin
      d = (sh & ~Frame9Mask) >> 4;
      nbits = 9;
      res.length = LenCode9;
    end else begin
      return 1'b0;
    end
    for (i = 0; i < nbits; i++) begin
      if (d[3:0] == NibbleOne) v[i] = 1'b1;
      else if (d[3:0] != NibbleZero) return 1'b0;
      d = d >> 4;
    end
    res.value = v;
    return 1'b1;
  endfunction

  task automatic shift_in(input logic [3:0] nib);
    dec_shift = (dec_shift << 4) | 64'(nib);
    if (dec_count != 4'd15) dec_count = dec_count + 4'd1;
  endtask

  task automatic decode_pulse(input logic lvl, input logic [23:0] dur, output logic made,
                              output code_t res);
    made = 1'b0;
    res  = '0;
    case (dec_phase)
      PhIdle: begin
        if (!lvl && close_to(64'(dur), 64'(cfg_unit) * HeaderUnits,
                             64'(cfg_tol) * HeaderTolScale)) begin
          dec_phase = PhStart;
        end
      end
      PhStart: begin
        if (lvl && near_unit(64'(dur), 1)) begin
          dec_shift = '0;
          dec_count = '0;
          shift_in(NibbleStop);
          dec_phase = PhLow;
        end else begin
          dec_phase = PhIdle;
        end
      end
      PhLow: begin
        if (lvl) begin
          dec_phase = PhIdle;
        end else if (64'(dur) > 64'(cfg_unit) * GapUnits) begin
          if (dec_count >= MinFrameNibbles && unpack_frame(dec_shift, dec_count, res)) begin
            made = 1'b1;
          end
          dec_phase = PhIdle;
        end else begin
          dec_low   = dur;
          dec_phase = PhHigh;
        end
      end
      default: begin
        dec_phase = PhLow;
        if (!lvl) dec_phase = PhIdle;
        else if (near_unit(64'(dec_low), 3) && near_unit(64'(dur), 1)) shift_in(NibbleStop);
        else if (near_unit(64'(dec_low), 2) && near_unit(64'(dur), 2)) shift_in(NibbleOne);
        else if (near_unit(64'(dec_low), 1) && near_unit(64'(dur), 3)) shift_in(NibbleZero);
        else dec_phase = PhIdle;
      end
    endcase
  endtask

  // Duration around a nominal length; edge mode lands on the window boundary.
  function automatic logic [23:0] jitter_len(input longint unsigned nominal,
                                             input longint unsigned spread,
                                             input logic exact, input logic edgy);
    longint unsigned off;
    longint unsigned v;
    int unsigned     span;
    off = 0;
    if (!exact && spread != 0) begin
      if (edgy) begin
        off = $urandom_range(1) ? spread : spread - 1;
      end else begin
        span = 32'(spread - 1);
        off  = $urandom_range(span);
      end
    end
    if ($urandom_range(1)) v = nominal + off;
    else v = (off > nominal) ? 0 : nominal - off;
    if (v > MaxDur) v = MaxDur;
    return v[23:0];
  endfunction

  task automatic add_bit(ref sym_e syms[$], input logic b);
    syms.push_back(b ? SymOne : SymZero);
  endtask

  task automatic build_frame(input frame_kind_e kind, input logic [8:0] bits,
                             input logic exact);
    sym_e            syms [$];
    sym_e            dropped;
    int              width;
    int              k;
    int              n;
    int              idx;
    int unsigned     low_units;
    logic            edgy;
    longint unsigned u;
    longint unsigned t;
    longint unsigned gap_lo;
    longint unsigned gap;
    logic [23:0]     d;
    pulse_t          p;
    u    = cfg_unit;
    t    = cfg_tol;
    edgy = (kind == KindEdge);
    pulse_q.delete();
    if (kind == KindNoise) begin
      n = $urandom_range(6, 1);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(1)) d = 24'($urandom_range(MaxDur));
        else d = 24'($urandom_range(6 * cfg_unit));
        pulse_q.push_back({1'($urandom_range(1)), d});
      end
      return;
    end
    if (kind == KindExtremes) begin
      pulse_q.push_back({1'b1, 24'd0});
      pulse_q.push_back({1'b0, 24'd0});
      pulse_q.push_back({1'b1, MaxDur});
      pulse_q.push_back({1'b0, MaxDur});
      pulse_q.push_back({1'b0, jitter_len(u * HeaderUnits, 0, 1'b1, 1'b0)});
      pulse_q.push_back({1'b1, jitter_len(u, 0, 1'b1, 1'b0)});
      pulse_q.push_back({1'b0, 24'd0});
      pulse_q.push_back({1'b1, MaxDur});
      return;
    end
    case (kind)
      KindGood7: width = 7;
      KindGood8: width = 8;
      KindGood9: width = 9;
      default:   width = 7 + $urandom_range(2);
    endcase
    // Symbols in arrival order, oldest first, after the start pulse.
    case (width)
      7: begin
        for (k = 6; k >= 1; k--) add_bit(syms, bits[k]);
        syms.push_back(SymStop);
        syms.push_back(SymStop);
        add_bit(syms, bits[0]);
      end
      8: begin
        for (k = 7; k >= 3; k--) add_bit(syms, bits[k]);
        syms.push_back(SymStop);
        add_bit(syms, bits[1]);
        add_bit(syms, bits[0]);
      end
      default: begin
        for (k = 8; k >= 0; k--) add_bit(syms, bits[k]);
      end
    endcase
    syms.push_back(SymStop);
    if (kind == KindShort) begin
      n = $urandom_range(3, 1);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(1)) dropped = syms.pop_back();
        else dropped = syms.pop_front();
      end
    end
    if (kind == KindLong) begin
      n = $urandom_range(8, 1);
      for (k = 0; k < n; k++) syms.push_front(sym_e'($urandom_range(2)));
    end
    if (kind == KindBadNibble) begin
      idx = $urandom_range(syms.size() - 1);
      syms[idx] = (syms[idx] == SymStop) ? SymOne : SymStop;
    end
    pulse_q.push_back({1'b0, jitter_len(u * HeaderUnits, t * HeaderTolScale, exact, edgy)});
    pulse_q.push_back({1'b1, jitter_len(u, t, exact, edgy)});
    for (k = 0; k < syms.size(); k++) begin
      case (syms[k])
        SymStop: low_units = 3;
        SymOne:  low_units = 2;
        default: low_units = 1;
      endcase
      pulse_q.push_back({1'b0, jitter_len(u * low_units, t, exact, edgy)});
      pulse_q.push_back({1'b1, jitter_len(u * (4 - low_units), t, exact, edgy)});
    end
    gap_lo = u * GapUnits + 1;
    if (edgy) gap = $urandom_range(1) ? gap_lo : gap_lo - 1;
    else if ($urandom_range(1)) gap = gap_lo + $urandom_range(3 * cfg_unit);
    else gap = $urandom_range(MaxDur, 32'(gap_lo));
    if (gap > MaxDur) gap = MaxDur;
    pulse_q.push_back({1'b0, gap[23:0]});
    if (kind == KindWrongLevel) begin
      idx = $urandom_range(pulse_q.size() - 1);
      p = pulse_q[idx];
      p.lvl = ~p.lvl;
      pulse_q[idx] = p;
    end
    if (kind == KindUnmatched && syms.size() != 0) begin
      k = $urandom_range(syms.size() - 1);
      pulse_q[2 + 2 * k] = {1'b0, 24'($urandom_range(GapUnits * cfg_unit))};
      pulse_q[3 + 2 * k] = {1'b1, 24'($urandom_range(4 * cfg_unit))};
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pulse(input logic lvl, input logic [23:0] dur);
    logic  made;
    code_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push          <= 1'b1;
    level_i       <= lvl;
    duration_us_i <= dur;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    decode_pulse(lvl, dur, made, res);
    if (made) pending_codes.push_back(typed_on ? typed_code : res);
    pulses_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    foreach (pulse_q[k]) send_pulse(pulse_q[k].lvl, pulse_q[k].dur);
  endtask

  // A frame that ends in no code may still be in flight, hence the settle time.
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_codes.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == RegUnitTime) cfg_unit = data;
    else if (idx == RegTolerance) cfg_tol = data;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input logic [15:0] unit, input logic [15:0] tol,
                               input int idle, input int stall);
    logic [7:0] stray;
    wait_drained();
    stray = 8'($urandom_range(255, int'(RegTolerance) + 1));
    write_reg(stray, 16'($urandom_range(16'hFFFF)));
    write_reg(RegUnitTime, unit);
    write_reg(RegTolerance, tol);
    cfg_valid_i    <= 1'b0;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    settings_used++;
  endtask

  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_codes
    code_t want;
    if (rst_ni && pop && !empty) begin
      codes_popped++;
      if (pending_codes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("unexpected code: value %h length %0d", code_value_o, code_length_o);
        end
      end else begin
        want = pending_codes.pop_front();
        if (want.value !== code_value_o || want.length !== code_length_o) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("code mismatch: value exp %h got %h, length exp %0d got %0d",
                     want.value, code_value_o, want.length, code_length_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout with %0d codes outstanding", pending_codes.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int          round;
    int          round_items;
    int          round_len;
    int          random_items;
    int          r;
    frame_kind_e kind;
    logic [15:0] rand_unit;
    round        = 0;
    random_items = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int row = 0; row < DirRows; row++) begin
      typed_on   = dir_table[row].typed;
      typed_code = {dir_table[row].exp_value, dir_table[row].exp_length};
      build_frame(dir_table[row].kind, dir_table[row].bits, 1'b1);
      send_frame();
    end
    typed_on = 1'b0;

    while (random_items < RandomItems) begin
      rand_unit = 16'($urandom_range(16'hFFFF, 100));
      case (round % 6)
        0: apply_setting(16'd100, 16'd30, 59, 0);
        1: apply_setting(16'hFFFF, 16'hFFFF, 0, 59);
        2: apply_setting(rand_unit, 16'($urandom_range(rand_unit / 4)), 16, 16);
        3: apply_setting(16'd100, 16'd0, 0, 0);   // no pulse can match
        4: apply_setting(rand_unit, 16'($urandom_range(16'hFFFF)), 0, 59);
        default: apply_setting(UnitReset, TolReset, 16, 16);
      endcase
      round_len   = (round % 6 == 3) ? 60 : 220;
      round_items = 0;
      while (round_items < round_len) begin
        r = $urandom_range(99);
        if (r < 22) kind = KindGood9;
        else if (r < 42) kind = KindGood8;
        else if (r < 62) kind = KindGood7;
        else if (r < 67) kind = KindShort;
        else if (r < 72) kind = KindLong;
        else if (r < 78) kind = KindBadNibble;
        else if (r < 83) kind = KindWrongLevel;
        else if (r < 88) kind = KindUnmatched;
        else if (r < 94) kind = KindEdge;
        else kind = KindNoise;
        build_frame(kind, 9'($urandom_range(511)), 1'b0);
        send_frame();
        if (kind != KindNoise) begin
          round_items  += pulse_q.size();
          random_items += pulse_q.size();
        end
      end
      round++;
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("sent %0d pulses under %0d timing settings, checked %0d decoded codes",
             pulses_sent, settings_used, codes_popped);
    $display("frames: 7/8/9 switch, short, long, bad symbol, wrong level, noise, edges");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/dip_pkg.sv
src/dip_front.sv
src/dip_frame_q.sv
src/dip_back.sv
src/dip_remote_pulse_decoder_top.sv
test/tb_top.sv
